// ----- sv/gfp_pkg.sv -----
package gfp_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'h5A;
    localparam logic [7:0] TYPE_RATE = 8'hAA;
    localparam logic [7:0] TYPE_YAW  = 8'hBB;

    localparam logic KIND_RATE = 1'b0;
    localparam logic KIND_YAW  = 1'b1;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic signed [15:0] value;
    } t_result;

endpackage

// ----- sv/gfp_parser.sv -----
module gfp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output gfp_pkg::t_result o_result
);
    import gfp_pkg::*;

    localparam logic [2:0] POS_IDLE = 3'd0;
    localparam logic [2:0] POS_TYPE = 3'd1;
    localparam logic [2:0] POS_LO   = 3'd2;
    localparam logic [2:0] POS_HI   = 3'd3;
    localparam logic [2:0] POS_CHK  = 3'd4;

    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic [7:0] r_type;
    logic [7:0] r_lo;
    logic [7:0] r_hi;
    logic [7:0] w_sum;

    // header byte is always the constant, so it is not stored
    assign w_sum = HDR_BYTE + r_type + r_lo + r_hi;

    always_comb begin
        n_pos = r_pos;
        o_result.valid = 1'b0;
        o_result.kind  = (r_type == TYPE_YAW) ? KIND_YAW : KIND_RATE;
        o_result.value = signed'({r_hi, r_lo});
        unique case (r_pos)
            POS_TYPE: begin
                if (i_byte == TYPE_RATE || i_byte == TYPE_YAW) begin
                    n_pos = POS_LO;
                end else if (i_byte == HDR_BYTE) begin
                    n_pos = POS_TYPE;
                end else begin
                    n_pos = POS_IDLE;
                end
            end
            POS_LO: begin
                n_pos = POS_HI;
            end
            POS_HI: begin
                n_pos = POS_CHK;
            end
            POS_CHK: begin
                n_pos = POS_IDLE;
                o_result.valid = (w_sum == i_byte);
            end
            default: begin
                n_pos = (i_byte == HDR_BYTE) ? POS_TYPE : POS_IDLE;
            end
        endcase
        if (!i_step) begin
            o_result.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
        end else if (i_step) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (r_pos == POS_TYPE) begin
                r_type <= i_byte;
            end
            if (r_pos == POS_LO) begin
                r_lo <= i_byte;
            end
            if (r_pos == POS_HI) begin
                r_hi <= i_byte;
            end
        end
    end

endmodule

// ----- sv/gyro_frame_parser.sv -----
// gyro_frame_parser
// parses five-byte gyro frames from a stream of received serial bytes
// input channel: i_in_valid / o_in_stall carry one byte per item on i_rx_byte
// output channel: o_out_valid / i_out_stall carry one measurement per item,
//   o_measurement_kind (0 z rate, 1 yaw) and o_raw_value (signed 16 bit)
// a frame is header 0x5a, type 0xaa or 0xbb, value low, value high, checksum;
//   only frames whose checksum matches produce an output item
// path: a frame's checksum byte goes through the input register, then its
//   result is captured in the result register that drives the output
// throughput: one byte per cycle while the output is not stalled, set by the
//   combinational parser decision between the input register and the result register
// reset (synchronous, active low) empties both registers and returns the
//   parser to waiting for a header
// when the receiver stalls, the result register holds; the input register
//   still accepts one more byte if it is empty, after which o_in_stall rises until the
//   output drains
module gyro_frame_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_measurement_kind,
    output logic signed [15:0] o_raw_value
);
    import gfp_pkg::*;

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    logic               r_out_kind;
    logic signed [15:0] r_out_value;
    logic               w_adv;
    logic               w_step;
    t_result            w_result;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;

    gfp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_result.valid) begin
            r_out_kind  <= w_result.kind;
            r_out_value <= w_result.value;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_measurement_kind = r_out_kind;
    assign o_raw_value        = r_out_value;

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked output");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result.valid |-> w_step)
        else $error("parser result without a processed item");

    a_fresh_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall) |=> (!r_out_valid || $past(w_step)))
        else $error("output item appeared without a parsed frame");
`endif

endmodule

// ----- bench/frame_checker.sv -----
`timescale 1ns / 100ps

module frame_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_measurement_kind,
    input  logic signed [15:0] i_raw_value,
    output int                 o_fail_count,
    output int                 o_pending
);
    import gfp_pkg::*;

    typedef enum logic [2:0] {
        WAIT_HDR,
        GOT_HDR,
        GOT_TYPE,
        GOT_LO,
        GOT_HI
    } t_frame_pos;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] value;
    } t_measurement;

    t_frame_pos   frame_pos = WAIT_HDR;
    logic [7:0]   hdr_byte;
    logic [7:0]   type_byte;
    logic [7:0]   value_lo;
    logic [7:0]   value_hi;
    t_measurement expected_meas_q[$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [7:0]   sum;
        t_measurement meas;
        case (frame_pos)
            GOT_HDR: begin
                if (b == TYPE_RATE || b == TYPE_YAW) begin
                    type_byte = b;
                    frame_pos = GOT_TYPE;
                end else if (b == HDR_BYTE) begin
                    hdr_byte  = b;
                    frame_pos = GOT_HDR;
                end else begin
                    frame_pos = WAIT_HDR;
                end
            end
            GOT_TYPE: begin
                value_lo  = b;
                frame_pos = GOT_LO;
            end
            GOT_LO: begin
                value_hi  = b;
                frame_pos = GOT_HI;
            end
            GOT_HI: begin
                frame_pos = WAIT_HDR;
                sum = hdr_byte + type_byte + value_lo + value_hi;
                if (sum == b) begin
                    meas.kind  = (type_byte == TYPE_YAW) ? KIND_YAW : KIND_RATE;
                    meas.value = {value_hi, value_lo};
                    expected_meas_q.push_back(meas);
                end
            end
            default: begin
                if (b == HDR_BYTE) begin
                    hdr_byte  = b;
                    frame_pos = GOT_HDR;
                end else begin
                    frame_pos = WAIT_HDR;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_measurement want;
        if (!i_rst_n) begin
            frame_pos = WAIT_HDR;
            expected_meas_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_meas_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item kind %0d value %0d",
                                              i_measurement_kind, i_raw_value));
                end else begin
                    want = expected_meas_q.pop_front();
                    if (i_measurement_kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  i_measurement_kind, want.kind));
                    if (i_raw_value !== want.value)
                        report_mismatch($sformatf("raw value %0d, want %0d",
                                                  i_raw_value, want.value));
                end
            end
            if (i_in_valid && !i_in_stall)
                parse_rx_byte(i_rx_byte);
        end
        o_pending = expected_meas_q.size();
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import gfp_pkg::*;

    localparam int TOTAL_ITEMS    = 1350;
    localparam int TAIL_ITEMS     = 150;
    localparam int PRESSURE_START = 400;
    localparam int PRESSURE_LEN   = 60;
    localparam int LONG_HOLD      = 80;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 10;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [7:0]         i_rx_byte   = 8'h00;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_measurement_kind;
    logic signed [15:0] o_raw_value;

    int fail_count;
    int pending;
    int items_sent    = 0;
    int idle_cycles   = 0;
    bit quiet_tail    = 1'b0;
    bit pressure_on   = 1'b0;
    bit long_hold_req = 1'b0;
    bit hold_done     = 1'b0;

    gyro_frame_parser DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_rx_byte          (i_rx_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_measurement_kind (o_measurement_kind),
        .o_raw_value        (o_raw_value)
    );

    frame_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_rx_byte          (i_rx_byte),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_measurement_kind (o_measurement_kind),
        .i_raw_value        (o_raw_value),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // no progress on either channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver stall
    always begin
        @(negedge i_clk);
        if (quiet_tail) begin
            i_out_stall <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            i_out_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge i_clk);
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_rx_byte(input logic [7:0] b);
        bit taken;
        if (!quiet_tail && !pressure_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
            @(negedge i_clk);
        end
        items_sent++;
    endtask

    task automatic send_frame(input logic [7:0] kind_byte, input logic [15:0] value,
                              input bit bad_sum);
        logic [7:0] sum;
        sum = HDR_BYTE + kind_byte + value[7:0] + value[15:8];
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_rx_byte(HDR_BYTE);
        send_rx_byte(kind_byte);
        send_rx_byte(value[7:0]);
        send_rx_byte(value[15:8]);
        send_rx_byte(sum);
    endtask

    initial begin
        int         pick;
        logic [7:0] kind_byte;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle junk, bad type, header resync, value extremes, bad checksum
        send_rx_byte(8'h00);
        send_rx_byte(HDR_BYTE);
        send_rx_byte(8'h13);
        send_rx_byte(HDR_BYTE);
        send_frame(TYPE_YAW, 16'h8000, 1'b0);
        send_frame(TYPE_RATE, 16'h7FFF, 1'b0);
        send_frame(TYPE_RATE, 16'h0000, 1'b1);
        send_rx_byte(8'hFF);
        send_frame(TYPE_YAW, 16'hFFFF, 1'b0);

        while (items_sent < TOTAL_ITEMS) begin
            quiet_tail  = (items_sent >= TOTAL_ITEMS - TAIL_ITEMS);
            pressure_on = (items_sent >= PRESSURE_START &&
                           items_sent < PRESSURE_START + PRESSURE_LEN);
            if (pressure_on && !hold_done) begin
                long_hold_req = 1'b1;
                hold_done     = 1'b1;
            end
            kind_byte = $urandom_range(0, 1) ? TYPE_YAW : TYPE_RATE;
            pick      = $urandom_range(0, 99);
            if (pick < 65 || pressure_on) begin
                send_frame(kind_byte, 16'($urandom), $urandom_range(0, 6) == 0);
            end else if (pick < 75) begin
                send_rx_byte(HDR_BYTE);
                send_rx_byte($urandom_range(0, 3) == 0 ? HDR_BYTE : 8'($urandom));
            end else if (pick < 85) begin
                // frame cut short, the next bytes are taken as its tail
                send_rx_byte(HDR_BYTE);
                send_rx_byte(kind_byte);
                if ($urandom_range(0, 1))
                    send_rx_byte(8'($urandom));
            end else begin
                send_rx_byte(8'($urandom));
            end
        end

        quiet_tail = 1'b1;
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
